[rtl/nnsb_pkg.sv]
package nnsb_pkg;

	localparam int COORD_W   = 16;
	localparam int DIM_W     = 10;
	localparam int COLOR_W   = 8;
	localparam int MODE_W    = 3;
	localparam int RMODE_W   = 8;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int PIX_IDX_W = 16;
	localparam int PROD_W    = 2 * DIM_W;

	localparam int STORE_PIXELS_DEF = 65536;
	localparam int DIM_MAX_DEF      = 1023;

	localparam logic ACT_LOAD = 1'b0;
	localparam logic ACT_DRAW = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DEST_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RASTER_MODE = 3'd6;

	localparam logic [MODE_W-1:0] MODE_COPY = 3'd0;
	localparam logic [MODE_W-1:0] MODE_XOR  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_OR   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_AND  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_NOT  = 3'd4;

endpackage

[rtl/nnsb_cmd_if.sv]
interface nnsb_cmd_if;
	import nnsb_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 action;
	logic [PIX_IDX_W-1:0] pixel_index;
	logic [COLOR_W-1:0]   pixel_value;

	modport source (output valid, action, pixel_index, pixel_value, input ready);
	modport sink   (input valid, action, pixel_index, pixel_value, output ready);

endinterface

[rtl/nnsb_pix_if.sv]
interface nnsb_pix_if;
	import nnsb_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] out_x;
	logic signed [COORD_W-1:0] out_y;
	logic        [COLOR_W-1:0] out_color;
	logic        [MODE_W-1:0]  out_mode;
	logic                      frame_last;

	modport source (output valid, out_x, out_y, out_color, out_mode, frame_last, input ready);
	modport sink   (input valid, out_x, out_y, out_color, out_mode, frame_last, output ready);

endinterface

[rtl/nearest_neighbor_scaled_blit_top.sv]
// Nearest-neighbor scaled blit. Source pixels are loaded into an on-chip store by
// index (action 0); each draw request (action 1) emits the next destination pixel
// in raster order with its color taken from the truncated nearest-neighbor source
// position. Loads and draws are taken at one request per clock as long as the
// pixel output is being drained; a draw result appears in the cycle after its
// request through the store's registered read port. Source positions are stepped
// incrementally per pixel. Every configuration write starts a setup pass (a
// multiply state, four divisions of a 20-bit dividend on a shared restoring
// divider, and a second multiply state) during which no request is taken; draws
// while any size is zero or src_width * src_height exceeds the store are dropped.
module nearest_neighbor_scaled_blit_top #(
	parameter int STORE_PIXELS = nnsb_pkg::STORE_PIXELS_DEF,
	parameter int DIM_MAX      = nnsb_pkg::DIM_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nnsb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nnsb_pkg::CFG_W-1:0]     cfg_data,
	nnsb_cmd_if.sink                       cmd,
	nnsb_pix_if.source                     pix
);
	import nnsb_pkg::*;

	localparam int STORE_DEPTH = (STORE_PIXELS < (1 << PIX_IDX_W)) ? STORE_PIXELS
	                                                               : (1 << PIX_IDX_W);
	localparam int AW    = $clog2(STORE_DEPTH);
	localparam int CNT_W = $clog2(PROD_W);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_BASE} state_t;
	typedef enum logic [1:0] {OP_QX, OP_SX, OP_QY, OP_SY} div_op_t;

	function automatic logic [DIM_W-1:0] dim_sat(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] d;
		d = v[DIM_W-1:0];
		return (32'(d) > DIM_MAX) ? DIM_W'(DIM_MAX) : d;
	endfunction

	// configuration
	logic [COORD_W-1:0] dest_x_q, dest_y_q;
	logic [DIM_W-1:0]   sw_q, sh_q, dw_q, dh_q;
	logic [RMODE_W-1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q <= '0;
			dest_y_q <= '0;
			sw_q     <= '0;
			sh_q     <= '0;
			dw_q     <= '0;
			dh_q     <= '0;
			mode_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEST_X:      dest_x_q <= cfg_data;
				REG_DEST_Y:      dest_y_q <= cfg_data;
				REG_SRC_WIDTH:   sw_q     <= dim_sat(cfg_data);
				REG_SRC_HEIGHT:  sh_q     <= dim_sat(cfg_data);
				REG_DST_WIDTH:   dw_q     <= dim_sat(cfg_data);
				REG_DST_HEIGHT:  dh_q     <= dim_sat(cfg_data);
				REG_RASTER_MODE: mode_q   <= cfg_data[RMODE_W-1:0];
				default: ;
			endcase
		end
	end

	// control state
	state_t           state_q;
	div_op_t          op_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cfg_ok_q;
	logic             s1_valid_q;
	logic [DIM_W-1:0] col_q, row_q;

	// datapath state
	logic [PROD_W-1:0] area_q, colprod_q, rowprod_q;
	logic [PROD_W-1:0] div_n_q;
	logic [DIM_W-1:0]  div_r_q, div_d_q;
	logic [DIM_W-1:0]  qx_q, rx_q, qy_q, ry_q, sy_q;
	logic [DIM_W-1:0]  sx_q, remx_q, remy_q;
	logic [PROD_W-1:0] base_q, qysw_q;

	logic signed [COORD_W-1:0] x_s1, y_s1;
	logic        [MODE_W-1:0]  mode_s1;
	logic                      last_s1;
	logic        [COLOR_W-1:0] color_s1;

	logic [COLOR_W-1:0] store_mem [STORE_DEPTH];

	// request side
	logic accept, emit, load_we;
	assign cmd.ready = (state_q == ST_IDLE) && (!s1_valid_q || pix.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign emit      = accept && (cmd.action == ACT_DRAW) && cfg_ok_q;
	assign load_we   = accept && (cmd.action == ACT_LOAD) &&
	                   (32'(cmd.pixel_index) < STORE_PIXELS);

	// effective counters and incremental stepping
	logic [DIM_W-1:0]  col_e, row_e;
	logic              col_end, row_end;
	logic [DIM_W:0]    sum_x, sum_y;
	logic              cx, cy;
	logic [DIM_W-1:0]  remx_nx, remy_nx, sx_nx;
	logic [PROD_W-1:0] base_nx, rd_addr;

	assign col_e   = (col_q < dw_q) ? col_q : '0;
	assign row_e   = (row_q < dh_q) ? row_q : '0;
	assign col_end = (col_e == dw_q - DIM_W'(1));
	assign row_end = (row_e == dh_q - DIM_W'(1));
	assign sum_x   = {1'b0, remx_q} + {1'b0, rx_q};
	assign sum_y   = {1'b0, remy_q} + {1'b0, ry_q};
	assign cx      = (sum_x >= {1'b0, dw_q});
	assign cy      = (sum_y >= {1'b0, dh_q});
	assign remx_nx = cx ? DIM_W'(sum_x - {1'b0, dw_q}) : sum_x[DIM_W-1:0];
	assign remy_nx = cy ? DIM_W'(sum_y - {1'b0, dh_q}) : sum_y[DIM_W-1:0];
	assign sx_nx   = sx_q + qx_q + DIM_W'(cx);
	assign base_nx = base_q + qysw_q + (cy ? PROD_W'(sw_q) : '0);
	assign rd_addr = base_q + PROD_W'(sx_q);

	// divider step
	logic [DIM_W:0]    trial;
	logic              ge;
	logic [DIM_W-1:0]  div_r_nx;
	logic [PROD_W-1:0] div_q_nx;
	logic              div_done;

	assign trial    = {div_r_q, div_n_q[PROD_W-1]};
	assign ge       = (trial >= {1'b0, div_d_q});
	assign div_r_nx = ge ? DIM_W'(trial - {1'b0, div_d_q}) : trial[DIM_W-1:0];
	assign div_q_nx = {div_n_q[PROD_W-2:0], ge};
	assign div_done = (cnt_q == CNT_W'(PROD_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_QX;
			cnt_q      <= '0;
			cfg_ok_q   <= 1'b0;
			s1_valid_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			if (emit) begin
				s1_valid_q <= 1'b1;
			end else if (pix.ready) begin
				s1_valid_q <= 1'b0;
			end
			if (emit) begin
				col_q <= col_end ? '0 : col_e + DIM_W'(1);
				row_q <= col_end ? (row_end ? '0 : row_e + DIM_W'(1)) : row_e;
			end
			if (cfg_we) begin
				state_q <= ST_MUL;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_MUL: begin
						state_q <= ST_DIV;
						op_q    <= OP_QX;
						cnt_q   <= '0;
					end
					ST_DIV: begin
						cnt_q <= div_done ? '0 : cnt_q + CNT_W'(1);
						if (div_done) begin
							unique case (op_q)
								OP_QX: op_q <= OP_SX;
								OP_SX: op_q <= OP_QY;
								OP_QY: op_q <= OP_SY;
								OP_SY: state_q <= ST_BASE;
							endcase
						end
					end
					ST_BASE: begin
						state_q  <= ST_IDLE;
						cfg_ok_q <= (sw_q != '0) && (sh_q != '0) && (dw_q != '0) &&
						            (dh_q != '0) && (32'(area_q) <= STORE_PIXELS);
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (emit) begin
					if (col_end) begin
						sx_q   <= '0;
						remx_q <= '0;
						if (row_end) begin
							remy_q <= '0;
							base_q <= '0;
						end else begin
							remy_q <= remy_nx;
							base_q <= base_nx;
						end
					end else begin
						sx_q   <= sx_nx;
						remx_q <= remx_nx;
					end
				end
			end
			ST_MUL: begin
				area_q    <= sw_q * sh_q;
				colprod_q <= col_e * sw_q;
				rowprod_q <= row_e * sh_q;
				div_n_q   <= PROD_W'(sw_q);
				div_d_q   <= dw_q;
				div_r_q   <= '0;
			end
			ST_DIV: begin
				if (div_done) begin
					div_r_q <= '0;
					unique case (op_q)
						OP_QX: begin
							qx_q    <= div_q_nx[DIM_W-1:0];
							rx_q    <= div_r_nx;
							div_n_q <= colprod_q;
							div_d_q <= dw_q;
						end
						OP_SX: begin
							sx_q    <= div_q_nx[DIM_W-1:0];
							remx_q  <= div_r_nx;
							div_n_q <= PROD_W'(sh_q);
							div_d_q <= dh_q;
						end
						OP_QY: begin
							qy_q    <= div_q_nx[DIM_W-1:0];
							ry_q    <= div_r_nx;
							div_n_q <= rowprod_q;
							div_d_q <= dh_q;
						end
						OP_SY: begin
							sy_q   <= div_q_nx[DIM_W-1:0];
							remy_q <= div_r_nx;
						end
					endcase
				end else begin
					div_n_q <= div_q_nx;
					div_r_q <= div_r_nx;
				end
			end
			ST_BASE: begin
				base_q <= sy_q * sw_q;
				qysw_q <= qy_q * sw_q;
			end
		endcase
	end

	// source store and output stage
	always_ff @(posedge clk) begin
		if (load_we) begin
			store_mem[cmd.pixel_index[AW-1:0]] <= cmd.pixel_value;
		end
		if (emit) begin
			color_s1 <= store_mem[rd_addr[AW-1:0]];
			x_s1     <= dest_x_q + COORD_W'(col_e);
			y_s1     <= dest_y_q + COORD_W'(row_e);
			mode_s1  <= (mode_q > RMODE_W'(MODE_NOT)) ? MODE_COPY : mode_q[MODE_W-1:0];
			last_s1  <= col_end && row_end;
		end
	end

	assign pix.valid      = s1_valid_q;
	assign pix.out_x      = x_s1;
	assign pix.out_y      = y_s1;
	assign pix.out_color  = color_s1;
	assign pix.out_mode   = mode_s1;
	assign pix.frame_last = last_s1;

	assert property (@(posedge clk) disable iff (!arst_n)
		emit && !cfg_we |=> col_q < dw_q)
		else $error("column counter left the destination rectangle");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit && !cfg_we |=> remx_q < dw_q)
		else $error("column remainder not below destination width");

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> 32'(rd_addr) < 32'(area_q))
		else $error("store read outside source image");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s1_valid_q) |-> $past(emit))
		else $error("result raised without a draw request");

endmodule
